// ----- design/sha256_stream_hasher_unit_defines.svh -----
// assertion macros used by the sha256 stream hasher controller
// included by files that carry concurrent checks
`ifndef SHA256_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA256_STREAM_HASHER_UNIT_DEFINES_SVH

// implication check, disabled during reset
`define SHS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication check, disabled during reset
`define SHS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ----- design/shs_pkg.sv -----
// types and constants for the sha256 stream hasher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package shs_pkg;

    localparam int unsigned PadLenPos  = 56;
    localparam logic [7:0]  PadByte    = 8'h80;

    typedef logic [31:0] word_t;

    // datapath commands from the controller
    typedef struct packed {
        logic wr_byte;     // store data byte at byte position
        logic pad_first;   // write 0x80 at position, zero rest
        logic clr_block;   // zero whole block (fresh pad block)
        logic put_len;     // write length into bytes 56..63
        logic start;       // load working vars, begin rounds
        logic round;       // do one round
        logic fold;        // add working vars into hash
        logic reinit;      // restore initial state
    } cmd_t;

    // datapath status to the controller
    typedef struct packed {
        logic       blk_full;   // byte position wraps on this write
        logic       pad_extra;  // padding needs a second block
        logic       last_round;
    } stat_t;

    function automatic word_t init_h(input logic [2:0] i);
        word_t r;
        unique case (i)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic word_t round_k(input logic [5:0] i);
        word_t r;
        unique case (i)
            6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
            6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
            6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
            6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
            6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
            6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/sha256_stream_hasher_unit.sv -----
// sha256 stream hasher: top level joining controller and datapath
// depends on shs_pkg, shs_ctrl, shs_datapath
//
// usage:
//   input channel (in_valid/in_ready) takes one word per item: kind 0 with a
//   message byte, or kind 1 to finish the message.
//   output channel (out_valid/out_ready) gives eight digest words, index 0
//   first, last_word set on index 7.
//   a byte that does not fill the block leaves the input ready; a byte that fills
//   the block runs a compression (load, 64 rounds at one round per cycle in a
//   single shared round unit, fold) before the next word is taken.
//   finish pads the block and runs one or two compressions (two blocks when 56
//   or more bytes sit in the block) before the first digest word, then eight
//   words at one per cycle while out_ready is high, then the hash is reinitialized.
//   while out_ready is low the current digest word holds and no input is
//   taken. reset restores the initial hash, empties the block and clears the
//   length; the block storage itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sha256_stream_hasher_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        kind,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    shs_pkg::cmd_t  cmd;
    shs_pkg::stat_t stat;
    logic [2:0]     rd_sel;

    shs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd),
        .rd_sel    (rd_sel)
    );

    shs_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (data_byte),
        .rd_sel    (rd_sel),
        .stat      (stat),
        .hash_word (digest_word)
    );

    assign word_index = rd_sel;
    assign last_word  = (rd_sel == 3'd7);

endmodule

`default_nettype wire

// ----- design/shs_datapath.sv -----
// sha256 datapath: block buffer, message schedule, round unit, hash
// depends on shs_pkg
`timescale 1ns / 1ps
`default_nettype none

module shs_datapath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire shs_pkg::cmd_t   cmd,
    input  wire logic [7:0]      data_byte,
    input  wire logic [2:0]      rd_sel,
    output shs_pkg::stat_t       stat,
    output shs_pkg::word_t       hash_word
);

    // block buffer held as sixteen big-endian words
    shs_pkg::word_t blk_reg [16];
    shs_pkg::word_t blk_next [16];
    shs_pkg::word_t h_reg [8];
    shs_pkg::word_t v_reg [8];
    shs_pkg::word_t v_next [8];
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] len_reg, len_next;
    logic [5:0]  rnd_reg;

    // schedule: the block window shifts by one word each round
    shs_pkg::word_t w15, w2, s0, s1, w_new, t1, t2, e, a;

    always_comb
    begin
        w15   = blk_reg[1];
        w2    = blk_reg[14];
        s0    = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
        s1    = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
        w_new = s1 + blk_reg[9] + s0 + blk_reg[0];
        e     = v_reg[4];
        a     = v_reg[0];
        t1    = v_reg[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
              + ((e & v_reg[5]) ^ (~e & v_reg[6])) + shs_pkg::round_k(rnd_reg) + blk_reg[0];
        t2    = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
              + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        v_next[0] = t1 + t2;
        v_next[1] = v_reg[0];
        v_next[2] = v_reg[1];
        v_next[3] = v_reg[2];
        v_next[4] = v_reg[3] + t1;
        v_next[5] = v_reg[4];
        v_next[6] = v_reg[5];
        v_next[7] = v_reg[6];
    end

    // block buffer updates
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            blk_next[i] = blk_reg[i];
        end
        pos_next = pos_reg;
        len_next = len_reg;
        if (cmd.wr_byte)
        begin
            unique case (pos_reg[1:0])
                2'd0: blk_next[pos_reg[5:2]][31:24] = data_byte;
                2'd1: blk_next[pos_reg[5:2]][23:16] = data_byte;
                2'd2: blk_next[pos_reg[5:2]][15:8]  = data_byte;
                default: blk_next[pos_reg[5:2]][7:0] = data_byte;
            endcase
            pos_next = pos_reg + 6'd1;
            len_next = len_reg + 64'd8;
        end
        else if (cmd.pad_first)
        begin
            for (int i = 0; i < 16; i++)
            begin
                if (4'(i) > pos_reg[5:2])
                begin
                    blk_next[i] = '0;
                end
            end
            unique case (pos_reg[1:0])
                2'd0: blk_next[pos_reg[5:2]] = {shs_pkg::PadByte, 24'd0};
                2'd1: blk_next[pos_reg[5:2]][23:0] = {shs_pkg::PadByte, 16'd0};
                2'd2: blk_next[pos_reg[5:2]][15:0] = {shs_pkg::PadByte, 8'd0};
                default: blk_next[pos_reg[5:2]][7:0] = shs_pkg::PadByte;
            endcase
        end
        else if (cmd.clr_block)
        begin
            for (int i = 0; i < 16; i++)
            begin
                blk_next[i] = '0;
            end
        end
        else if (cmd.put_len)
        begin
            blk_next[14] = len_reg[63:32];
            blk_next[15] = len_reg[31:0];
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                blk_next[i] = blk_reg[i + 1];
            end
            blk_next[15] = w_new;
        end
        if (cmd.reinit)
        begin
            pos_next = '0;
            len_next = '0;
        end
    end

    // block words need no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 16; i++)
        begin
            blk_reg[i] <= blk_next[i];
        end
        if (cmd.start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= v_next[i];
            end
        end
    end

    // control registers and chaining hash
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            len_reg <= '0;
            rnd_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= shs_pkg::init_h(3'(i));
            end
        end
        else
        begin
            pos_reg <= pos_next;
            len_reg <= len_next;
            if (cmd.start)
            begin
                rnd_reg <= '0;
            end
            else if (cmd.round)
            begin
                rnd_reg <= rnd_reg + 6'd1;
            end
            if (cmd.reinit)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= shs_pkg::init_h(3'(i));
                end
            end
            else if (cmd.fold)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end
        end
    end

    // status to controller
    assign stat.blk_full   = (pos_reg == 6'd63);
    assign stat.pad_extra  = (pos_reg >= 6'(shs_pkg::PadLenPos));
    assign stat.last_round = (rnd_reg == 6'd63);
    assign hash_word       = h_reg[rd_sel];

endmodule

`default_nettype wire

// ----- design/shs_ctrl.sv -----
// sha256 controller: byte intake, padding sequence, rounds, digest output
// depends on shs_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "sha256_stream_hasher_unit_defines.svh"

module shs_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           kind,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire shs_pkg::stat_t stat,
    output shs_pkg::cmd_t       cmd,
    output logic [2:0]          rd_sel
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ROUND = 8'b0000_0010,
        S_FOLD  = 8'b0000_0100,
        S_PADZ  = 8'b0000_1000,
        S_LEN   = 8'b0001_0000,
        S_START = 8'b0010_0000,
        S_OUT   = 8'b0100_0000,
        S_INIT  = 8'b1000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic       fin_reg, fin_next;     // compression belongs to finish
    logic       two_reg, two_next;     // extra pad block pending
    logic [2:0] idx_reg, idx_next;

    logic acc;
    assign acc = in_valid && in_ready;

    // last digest word taken this cycle
    logic last_acc;
    assign last_acc = out_valid && out_ready && (idx_reg == 3'd7);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        two_next   = two_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (!kind)
                    begin
                        cmd.wr_byte = 1'b1;
                        fin_next    = 1'b0;
                        if (stat.blk_full)
                        begin
                            state_next = S_START;
                        end
                    end
                    else
                    begin
                        cmd.pad_first = 1'b1;
                        fin_next      = 1'b1;
                        two_next      = stat.pad_extra;
                        state_next    = stat.pad_extra ? S_START : S_LEN;
                    end
                end
            end
            S_LEN:
            begin
                cmd.put_len = 1'b1;
                state_next  = S_START;
            end
            S_START:
            begin
                cmd.start  = 1'b1;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                if (stat.last_round)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                cmd.fold = 1'b1;
                if (!fin_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (two_reg)
                begin
                    two_next   = 1'b0;
                    state_next = S_PADZ;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_OUT;
                end
            end
            S_PADZ:
            begin
                cmd.clr_block = 1'b1;
                state_next    = S_LEN;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                cmd.reinit = 1'b1;
                fin_next   = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin_reg   <= 1'b0;
            two_reg   <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            two_reg   <= two_next;
            idx_reg   <= idx_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign rd_sel    = idx_reg;

    // checks
    `SHS_ASSERT_IMP(a_out_only_fin, clk, rst_n, out_valid, fin_reg)
    `SHS_ASSERT_NXT(a_last_word_init, clk, rst_n, last_acc, state_reg == S_INIT)
    `SHS_ASSERT_NXT(a_fold_after_last, clk, rst_n, state_reg == S_ROUND && stat.last_round, state_reg == S_FOLD)

endmodule

`default_nettype wire

// ----- test/sha256_stream_hasher_unit_checker.sv -----
// digest checker for the sha256 stream hasher: predicts the hash of every message
// from the words seen on the input channel and compares the digest words
// depends on nothing but the channel signals of the block
`timescale 1ns / 1ps

module sha256_stream_hasher_unit_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic        kind,
    input  wire logic [7:0]  data_byte,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [31:0] digest_word,
    input  wire logic [2:0]  word_index,
    input  wire logic        last_word,
    output int               fail_count,
    output int               pending_words,
    output int               digests_seen
);

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    localparam logic [31:0] HashInit [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    logic [31:0]  hash_state [8];
    logic [7:0]   msg_block [64];
    logic [5:0]   fill_pos;
    logic [63:0]  bit_count;
    digest_word_t digest_queue [$];

    function automatic logic [31:0] ror(input logic [31:0] x, input int s);
        return (x >> s) | (x << (32 - s));
    endfunction

    // one 64-round compression of msg_block into hash_state
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        for (int i = 0; i < 8; i++)
            v[i] = hash_state[i];
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] = hash_state[i] + v[i];
    endtask

    task automatic restart_message();
        for (int i = 0; i < 8; i++)
            hash_state[i] = HashInit[i];
        fill_pos  = '0;
        bit_count = '0;
    endtask

    // padding, final compression and digest words for a finish word
    task automatic finish_message();
        int p;
        digest_word_t d;
        p = int'(fill_pos);
        msg_block[p] = 8'h80;
        p++;
        if (p > 56)
        begin
            while (p < 64)
            begin
                msg_block[p] = 8'h00;
                p++;
            end
            compress_block();
            p = 0;
        end
        while (p < 56)
        begin
            msg_block[p] = 8'h00;
            p++;
        end
        for (int i = 0; i < 8; i++)
            msg_block[56+i] = bit_count[63-8*i -: 8];
        compress_block();
        for (int i = 0; i < 8; i++)
        begin
            d.word  = hash_state[i];
            d.index = 3'(i);
            d.last  = (i == 7);
            digest_queue.push_back(d);
        end
        restart_message();
    endtask

    initial
    begin
        fail_count   = 0;
        digests_seen = 0;
        restart_message();
    end

    assign pending_words = digest_queue.size();

    // predict on accepted input words, compare accepted output words
    always @(posedge clk)
    begin
        digest_word_t exp_w;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (digest_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected digest word %h index %0d", digest_word, word_index);
                end
                else
                begin
                    exp_w = digest_queue.pop_front();
                    if (exp_w.last)
                        digests_seen++;
                    if (digest_word !== exp_w.word || word_index !== exp_w.index
                        || last_word !== exp_w.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                     exp_w.word, exp_w.index, exp_w.last,
                                     digest_word, word_index, last_word);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (kind)
                    finish_message();
                else
                begin
                    msg_block[fill_pos] = data_byte;
                    fill_pos  = fill_pos + 6'd1;
                    bit_count = bit_count + 64'd8;
                    if (fill_pos == 0)
                        compress_block();
                end
            end
        end
    end

endmodule

// ----- test/sha256_stream_hasher_unit_tb.sv -----
// testbench top for the sha256 stream hasher: drives message words with random
// gaps and output stalls, verdict from the digest checker
// depends on sha256_stream_hasher_unit and sha256_stream_hasher_unit_checker
`timescale 1ns / 1ps

module sha256_stream_hasher_unit_tb;

    localparam int CycleLimit = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    int          fail_count;
    int          pending_words;
    int          digests_seen;
    int          cycle_count;
    int          words_sent;
    bit          stall_on;

    sha256_stream_hasher_unit DUT (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .data_byte(data_byte), .out_valid(out_valid), .out_ready(out_ready),
        .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
    );

    sha256_stream_hasher_unit_checker checker_inst (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .data_byte(data_byte), .out_valid(out_valid), .out_ready(out_ready),
        .digest_word(digest_word), .word_index(word_index), .last_word(last_word),
        .fail_count(fail_count), .pending_words(pending_words), .digests_seen(digests_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if (stall_on == 1'b0)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 2);
    endfunction

    // timeout watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL sha256_stream_hasher_unit");
            $finish;
        end
    end

    // receiver stalls at random
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = (stall_on == 1'b0) ? 1'b1 : ($urandom_range(0, 3) != 0);
            if (stall_on && $urandom_range(0, 30) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(5, 30)) @(negedge clk);
            end
        end
    end

    // send one word and wait for acceptance
    task automatic send_word(input logic k, input logic [7:0] b);
        repeat (gap_len()) @(negedge clk);
        in_valid  = 1'b1;
        kind      = k;
        data_byte = b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
        @(negedge clk);
        in_valid  = 1'b0;
        kind      = 1'($urandom_range(0, 1));
        data_byte = 8'($urandom_range(0, 255));
    endtask

    task automatic send_message(input int len, input bit fixed, input logic [7:0] b);
        for (int i = 0; i < len; i++)
            send_word(1'b0, fixed ? b : 8'($urandom_range(0, 255)));
        send_word(1'b1, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        cycle_count = 0;
        words_sent  = 0;
        stall_on    = 1'b0;
        in_valid    = 1'b0;
        kind        = 1'b0;
        data_byte   = 8'h00;
        rst_n       = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty message with garbage data, one byte equal to the pad byte
        send_word(1'b1, 8'hff);
        send_message(1, 1'b1, 8'h80);

        // random data with stalls: 120 bytes fill one block and leave 56,
        // so the padding needs a second block
        stall_on = 1'b1;
        send_message(120, 1'b0, 8'h00);

        while (pending_words != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("sent %0d words, checked %0d digests including padding edge lengths",
                 words_sent, digests_seen);
        if (fail_count == 0)
            $display("PASS sha256_stream_hasher_unit");
        else
            $display("FAIL sha256_stream_hasher_unit");
        $finish;
    end

endmodule
